// ===== rtl/core/pcd_pkg.sv =====
// Shared types and constants for the post column decoder.
// Used by pcd_decode, pcd_out_reg, the top level and the checker; no dependencies.
package pcd_pkg;

  // Configuration register indexes.
  localparam logic CFG_ORIGIN_Y     = 1'b0;
  localparam logic CFG_CACHE_HEIGHT = 1'b1;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int ORIGIN_W = 16;
  localparam int HEIGHT_W = 11;
  localparam int ROW_W    = 10;
  // The row sum (signed origin plus two bytes) fits in 19 signed bits.
  localparam int POS_W    = 19;

  // Byte that closes a column.
  localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Decoder phase, one-hot.
  typedef enum logic [4:0] {
    PH_TOP  = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_PAD1 = 5'b00100,
    PH_PIX  = 5'b01000,
    PH_PAD2 = 5'b10000
  } phase_t;

  // One decoded result beat.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] pixel;
  } result_t;

endpackage

// ===== rtl/core/pcd_decode.sv =====
// Post stream parser: phase state, post counters and the row clip logic.
// Depends on pcd_pkg.
module pcd_decode
  import pcd_pkg::*;
#(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [BYTE_W-1:0]          stream_byte,
  input  logic signed [ORIGIN_W-1:0] origin_y,
  input  logic [HEIGHT_W-1:0]        cache_height,
  output result_t                    result
);

  localparam logic [POS_W-1:0] MAX_LIM = POS_W'(MAX_HEIGHT);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] top_row_r, top_row_nxt;
  logic [BYTE_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0] post_offset_r, post_offset_nxt;

  logic signed [POS_W-1:0] pos;
  logic [POS_W-1:0]        height_ext;
  logic [POS_W-1:0]        lim;
  logic                    in_range;
  logic [BYTE_W-1:0]       left_dec;

  // Destination row of the current pixel and its clip against the column height.
  always_comb begin
    pos = POS_W'(origin_y) + $signed({{(POS_W-BYTE_W){1'b0}}, top_row_r})
          + $signed({{(POS_W-BYTE_W){1'b0}}, post_offset_r});
    height_ext = POS_W'(cache_height);
    lim        = (height_ext > MAX_LIM) ? MAX_LIM : height_ext;
    in_range   = !pos[POS_W-1] && (pos[POS_W-1:0] < lim);
    left_dec   = bytes_left_r - 1'b1;
  end

  // Phase update and result for one byte.
  always_comb begin
    phase_nxt       = phase_r;
    top_row_nxt     = top_row_r;
    bytes_left_nxt  = bytes_left_r;
    post_offset_nxt = post_offset_r;
    result          = '0;
    case (phase_r)
      PH_LEN: begin
        bytes_left_nxt  = stream_byte;
        post_offset_nxt = '0;
        phase_nxt       = PH_PAD1;
      end
      PH_PAD1: begin
        phase_nxt = (bytes_left_r == '0) ? PH_PAD2 : PH_PIX;
      end
      PH_PIX: begin
        result.valid    = in_range;
        result.kind     = KIND_PIXEL;
        result.row      = pos[ROW_W-1:0];
        result.pixel    = stream_byte;
        post_offset_nxt = post_offset_r + 1'b1;
        bytes_left_nxt  = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_PAD2;
        end
      end
      PH_PAD2: begin
        phase_nxt = PH_TOP;
      end
      default: begin
        // Start of a post, or the end of the column.
        if (stream_byte == END_MARK) begin
          result.valid = 1'b1;
          result.kind  = KIND_END;
          phase_nxt    = PH_TOP;
        end else begin
          top_row_nxt = stream_byte;
          phase_nxt   = PH_LEN;
        end
      end
    endcase
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TOP;
      top_row_r     <= '0;
      bytes_left_r  <= '0;
      post_offset_r <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      top_row_r     <= top_row_nxt;
      bytes_left_r  <= bytes_left_nxt;
      post_offset_r <= post_offset_nxt;
    end
  end

endmodule

// ===== rtl/core/pcd_out_reg.sv =====
// Result register of the decoder: holds one beat until the consumer takes it.
// Depends on pcd_pkg.
module pcd_out_reg
  import pcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           result,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [ROW_W-1:0]  out_row,
  output logic [BYTE_W-1:0] out_pixel
);

  logic              valid_r, valid_nxt;
  logic              kind_r;
  logic [ROW_W-1:0]  row_r;
  logic [BYTE_W-1:0] pixel_r;

  // A new beat replaces the old one only when the old one is gone or leaving.
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= result.kind;
      row_r   <= result.row;
      pixel_r <= result.pixel;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_row   = row_r;
  assign out_pixel = pixel_r;

endmodule

// ===== rtl/core/post_column_decoder_core.sv =====
// Top level of the post column decoder: input register, parser and result register.
// Depends on pcd_pkg, pcd_decode and pcd_out_reg.
//
// The block takes one byte of a post-encoded column per beat and returns a pixel
// write for every pixel byte whose row (origin_y + top row + offset in the post)
// falls in 0 .. min(cache_height, MAX_HEIGHT) - 1, and an end-of-column beat for
// the closing 0xff byte; all other bytes give no result. It accepts a byte in
// every cycle while the consumer keeps up: each byte passes an input register and
// the parser logic (a 19-bit add and compare) into the result register.
// Configuration is read directly and must only be written while the block is idle.
module post_column_decoder_core
  import pcd_pkg::*;
#(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ORIGIN_W-1:0] cfg_wdata,
  // Byte stream in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_stream_byte,
  // Results out
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [ROW_W-1:0]    out_row,
  output logic [BYTE_W-1:0]   out_pixel
);

  logic signed [ORIGIN_W-1:0] origin_y_r;
  logic [HEIGHT_W-1:0]        cache_height_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_free;
  logic              step;
  logic              in_fire;
  result_t           result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_y_r     <= '0;
      cache_height_r <= HEIGHT_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        CFG_CACHE_HEIGHT: cache_height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: the held byte is processed when the result register can take it.
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  pcd_decode #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .stream_byte  (s1_byte_r),
    .origin_y     (origin_y_r),
    .cache_height (cache_height_r),
    .result       (result)
  );

  pcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && result.valid),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_row   (out_row),
    .out_pixel (out_pixel)
  );

endmodule

// ===== rtl/core/pcd_checker.sv =====
// Port-level checks for post_column_decoder_core, attached by a bind below.
// Depends on pcd_pkg.
module pcd_checker
  import pcd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_kind,
  input logic [ROW_W-1:0]  out_row,
  input logic [BYTE_W-1:0] out_pixel
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_kind, out_row, out_pixel}))
    else $error("result beat changed while stalled");

  // An end-of-column beat carries a zero row and pixel.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_row == '0 && out_pixel == '0)
    else $error("end-of-column beat with non-zero payload");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind post_column_decoder_core pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_row   (out_row),
  .out_pixel (out_pixel)
);

// ===== tb/tb_post_column_decoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for post_column_decoder_core: random post streams, predicted writes.
// Depends on pcd_pkg and the post_column_decoder_core RTL only.
module tb_post_column_decoder_core;
  import pcd_pkg::*;

  localparam int MAX_ROWS           = 1024;
  localparam int RESET_CYCLES       = 9;
  localparam int DRAIN_CYCLES       = 8;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int SETTINGS_RUN       = 9;
  localparam int BYTES_PER_SETTING  = 160;
  localparam int STALL_AFTER        = 200;
  localparam int STALL_CYCLES       = 160;

  // Opening column under reset configuration: a zero-length post near the
  // largest top row, the pixel extremes, a post crossing the bottom edge with
  // end-mark pad bytes, the column end and an empty column straight after it.
  localparam logic [BYTE_W-1:0] OPENING_COLUMN [19] = '{
    8'd254, 8'd0, 8'h5a, 8'h33,
    8'd5, 8'd2, 8'h00, 8'h00, 8'hff, 8'h00,
    8'd126, 8'd3, 8'hff, 8'h11, 8'h22, 8'h33, 8'hff,
    8'hff,
    8'hff
  };
  // With a negative origin the first rows of this post fall above the top.
  localparam logic [BYTE_W-1:0] ABOVE_TOP_COLUMN [8] = '{
    8'd0, 8'd3, 8'h00, 8'h44, 8'h55, 8'h66, 8'h00, 8'hff
  };

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] pixel;
  } col_write_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_ORIGIN_Y;
  logic [ORIGIN_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_stream_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_kind;
  logic [ROW_W-1:0]    out_row;
  logic [BYTE_W-1:0]   out_pixel;

  // Stimulus and expectation stores.
  logic [BYTE_W-1:0] stream_q [$];
  col_write_t        pending_writes [$];
  int                bytes_owed;
  int                idle_pct;
  int                errors;
  int                cycle_count;
  int                bytes_sent;
  int                pixels_seen;
  int                ends_seen;

  // Predictor copy of the registers and of the column parser.
  logic signed [ORIGIN_W-1:0] pred_origin;
  logic [HEIGHT_W-1:0]        pred_height;
  phase_t                     dec_phase;
  logic [BYTE_W-1:0]          dec_top;
  logic [BYTE_W-1:0]          dec_left;
  logic [BYTE_W-1:0]          dec_offset;

  post_column_decoder_core #(
    .MAX_HEIGHT(MAX_ROWS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_stream_byte(in_stream_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_row       (out_row),
    .out_pixel     (out_pixel)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Advances the column parser by one byte and queues the write it causes.
  task automatic parse_stream_byte(input logic [BYTE_W-1:0] b);
    int row_sum;
    int row_lim;
    case (dec_phase)
      PH_LEN: begin
        dec_left   = b;
        dec_offset = '0;
        dec_phase  = PH_PAD1;
      end
      PH_PAD1: begin
        dec_phase = (dec_left == 0) ? PH_PAD2 : PH_PIX;
      end
      PH_PIX: begin
        row_sum = int'(pred_origin) + int'(dec_top) + int'(dec_offset);
        row_lim = (pred_height > MAX_ROWS) ? MAX_ROWS : int'(pred_height);
        if (row_sum >= 0 && row_sum < row_lim) begin
          pending_writes.push_back('{KIND_PIXEL, row_sum[ROW_W-1:0], b});
        end
        dec_offset = dec_offset + 1'b1;
        dec_left   = dec_left - 1'b1;
        if (dec_left == 0) begin
          dec_phase = PH_PAD2;
        end
      end
      PH_PAD2: begin
        dec_phase = PH_TOP;
      end
      default: begin
        if (b == END_MARK) begin
          pending_writes.push_back('{KIND_END, '0, '0});
          dec_phase = PH_TOP;
        end else begin
          dec_top   = b;
          dec_phase = PH_LEN;
        end
      end
    endcase
  endtask

  // Driver: offers queued bytes, with random idle bursts between beats.
  always @(posedge clk) begin
    int src_gap;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      src_gap    = 0;
      dec_phase  = PH_TOP;
      dec_top    = '0;
      dec_left   = '0;
      dec_offset = '0;
    end else begin
      if (in_valid && in_ready) begin
        parse_stream_byte(in_stream_byte);
        bytes_owed--;
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_valid       <= 1'b1;
          in_stream_byte <= stream_q.pop_front();
          if ($urandom_range(99, 0) < idle_pct) begin
            src_gap = $urandom_range(15, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the result channel at random,
  // once for a long stretch so that the block backs up onto its input.
  always @(posedge clk) begin
    col_write_t want;
    int sink_gap;
    int hold_left;
    bit held_once;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
      held_once = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (out_kind == KIND_END) ends_seen++;
        else pixels_seen++;
        if (pending_writes.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: kind %0d row %0d pixel %0d",
                   $time, out_kind, out_row, out_pixel);
        end else begin
          want = pending_writes.pop_front();
          if (out_kind !== want.kind) begin
            errors++;
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, out_kind);
          end
          if (out_row !== want.row) begin
            errors++;
            $display("%0t: row mismatch: expected %0d, got %0d", $time, want.row, out_row);
          end
          if (out_pixel !== want.pixel) begin
            errors++;
            $display("%0t: pixel mismatch: expected %0d, got %0d",
                     $time, want.pixel, out_pixel);
          end
        end
      end
      if (!held_once && pixels_seen + ends_seen >= STALL_AFTER) begin
        held_once = 1'b1;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99, 0) < idle_pct) begin
          sink_gap = $urandom_range(15, 1);
        end
      end
    end
  end

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    stream_q.push_back(b);
    bytes_owed++;
  endfunction

  // Queues one column of random posts, now and then broken or preceded by noise.
  function automatic int queue_column();
    int posts;
    int post_len;
    int pick;
    int count;
    count = 0;
    if ($urandom_range(99, 0) < 4) begin
      repeat ($urandom_range(4, 1)) begin
        push_byte(BYTE_W'($urandom_range(255, 0)));
        count++;
      end
    end
    posts = $urandom_range(4, 0);
    repeat (posts) begin
      push_byte(BYTE_W'(($urandom_range(1, 0) == 1) ? $urandom_range(40, 0)
                                                      : $urandom_range(254, 0)));
      pick = $urandom_range(99, 0);
      if (pick < 15) post_len = 0;
      else if (pick < 90) post_len = $urandom_range(12, 1);
      else if (pick < 97) post_len = $urandom_range(60, 13);
      else if (pick < 99) post_len = $urandom_range(254, 61);
      else post_len = 255;
      push_byte(BYTE_W'(post_len));
      push_byte(BYTE_W'($urandom_range(255, 0)));
      repeat (post_len) push_byte(BYTE_W'($urandom_range(255, 0)));
      count += post_len + 3;
      // A missing closing pad byte throws the parser out of step.
      if ($urandom_range(99, 0) < 95) begin
        push_byte(BYTE_W'($urandom_range(255, 0)));
        count++;
      end
    end
    push_byte(END_MARK);
    return count + 1;
  endfunction

  task automatic write_reg(input logic idx, input logic [ORIGIN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_ORIGIN_Y) pred_origin = val;
    else pred_height = val[HEIGHT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every byte is taken and every expected beat has come back,
  // then lets bytes without a result leave the pipeline.
  task automatic wait_idle();
    while (bytes_owed != 0 || pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Timeout guard.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timed out with %0d beats outstanding", $time, pending_writes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed columns, then one random stretch per setting.
  initial begin
    logic [ORIGIN_W-1:0] origin_val;
    logic [HEIGHT_W-1:0] height_val;
    int queued;
    errors      = 0;
    cycle_count = 0;
    bytes_owed  = 0;
    bytes_sent  = 0;
    pixels_seen = 0;
    ends_seen   = 0;
    idle_pct    = 10;
    pred_origin = '0;
    pred_height = 11'd128;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_COLUMN[i]) push_byte(OPENING_COLUMN[i]);
    wait_idle();
    write_reg(CFG_ORIGIN_Y, -16'sd2);
    foreach (ABOVE_TOP_COLUMN[i]) push_byte(ABOVE_TOP_COLUMN[i]);
    wait_idle();

    for (int s = 0; s < SETTINGS_RUN; s++) begin
      idle_pct = $urandom_range(25, 5);
      case (s)
        0: begin origin_val = 16'd0;      height_val = 11'd128;  end
        1: begin origin_val = -16'sd20;   height_val = 11'd1024; end
        2: begin origin_val = 16'h8000;   height_val = 11'd2047; end
        3: begin origin_val = 16'h7fff;   height_val = 11'd1;    end
        4: begin origin_val = 16'd100;    height_val = 11'd0;    end
        5: begin origin_val = -16'sd5;    height_val = 11'd1025; end
        6: begin
          origin_val = ORIGIN_W'($urandom_range(600, 0) - 300);
          height_val = HEIGHT_W'($urandom_range(1024, 1));
        end
        7: begin
          origin_val = ORIGIN_W'($urandom_range(65535, 0));
          height_val = HEIGHT_W'($urandom_range(2047, 0));
        end
        default: begin
          // Closing stretch runs without any idling on either side.
          origin_val = -16'sd200;
          height_val = 11'd600;
          idle_pct   = 0;
        end
      endcase
      write_reg(CFG_ORIGIN_Y, origin_val);
      write_reg(CFG_CACHE_HEIGHT, {{(ORIGIN_W-HEIGHT_W){1'b0}}, height_val});
      queued = 0;
      while (queued < BYTES_PER_SETTING) queued += queue_column();
      wait_idle();
    end

    $display("Run sent %0d stream bytes over %0d register settings;", bytes_sent,
             SETTINGS_RUN + 2);
    $display("checked %0d pixel writes and %0d column ends, with one long result stall.",
             pixels_seen, ends_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pcd_pkg.sv
rtl/core/pcd_decode.sv
rtl/core/pcd_out_reg.sv
rtl/core/post_column_decoder_core.sv
rtl/core/pcd_checker.sv
tb/tb_post_column_decoder_core.sv
